// ===== rtl/core/mfpe_pkg.sv =====
// Shared command and pen codes for the monochrome framebuffer pen engine.
// No dependencies.
package mfpe_pkg;

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PEN_ERASE  = 2'd0,
    PEN_SET    = 2'd1,
    PEN_INVERT = 2'd2,
    PEN_NONE   = 2'd3
  } pen_t;

  localparam logic [7:0] FILL_ONES  = 8'hff;
  localparam logic [7:0] FILL_ZEROS = 8'h00;

endpackage

// ===== rtl/core/mono_framebuffer_pen_engine.sv =====
// Monochrome page framebuffer with point, line, fill and page-byte read commands.
// Depends on mfpe_pkg and mfpe_store.
// A point reads, writes and advances (S_PRD, S_PWR, S_ADV); a read goes through S_RRD
// and S_RDONE to the output word (given at once when out of range); a line runs those
// steps per pixel, plus S_NORM row steps on a sloped line. Fill writes one store byte
// per cycle (set/erase pen). One command at a time. Reset zeroes the store in a pass.
module mono_framebuffer_pen_engine #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_start_x,
  input  logic [7:0] in_start_y,
  input  logic [7:0] in_end_x,
  input  logic [7:0] in_end_y,
  input  logic [1:0] in_pen,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_page_byte
);

  localparam int PAGES  = (ROWS + 7) / 8;
  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_PRD, S_PWR, S_ADV, S_NORM, S_RRD, S_RDONE
  } state_t;

  typedef enum logic [1:0] { M_HORZ, M_VERT, M_SLOPE } mode_t;

  state_t            state_r;
  mode_t             mode_r;
  logic [7:0]        px_r, py_r, hi_r, dx_r;
  logic signed [8:0] dstep_r;
  logic signed [9:0] rem_r;
  logic [1:0]        pen_r;
  logic [7:0]        fill_r;
  logic [ADDR_W-1:0] sw_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;

  logic              accept;
  logic              on_screen;
  logic [ADDR_W-1:0] col_base, pix_addr, rd_addr_mux, waddr, raddr;
  logic [7:0]        rdata, bitmask, wdata_pix, wdata;
  logic              we;
  logic [7:0]        lo_x, hi_x, lo_y, hi_y, dx_abs;
  logic signed [8:0] dy_fwd;
  logic signed [9:0] rem_step;

  assign in_ready      = (state_r == S_IDLE) && !out_valid_r;
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_page_byte = out_byte_r;

  // Pixel and read addressing.
  assign col_base    = ADDR_W'(ADDR_W'(px_r) * ADDR_W'(PAGES));
  assign pix_addr    = col_base + ADDR_W'(py_r[7:3]);
  assign rd_addr_mux = col_base + ADDR_W'(py_r);
  assign on_screen   = ({1'b0, px_r} < 9'(COLUMNS)) && ({1'b0, py_r} < 9'(ROWS));

  // Read-modify-write of one pixel bit.
  assign bitmask = 8'd1 << py_r[2:0];
  always_comb begin
    case (pen_r)
      mfpe_pkg::PEN_SET:    wdata_pix = rdata | bitmask;
      mfpe_pkg::PEN_INVERT: wdata_pix = rdata ^ bitmask;
      default:              wdata_pix = rdata & ~bitmask;
    endcase
  end

  assign we    = (state_r == S_SWEEP) || (state_r == S_PWR);
  assign waddr = (state_r == S_SWEEP) ? sw_r : pix_addr;
  assign wdata = (state_r == S_SWEEP) ? fill_r : wdata_pix;
  assign raddr = (state_r == S_RRD) ? rd_addr_mux : pix_addr;

  mfpe_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Line setup terms from the incoming word.
  assign lo_x   = (in_start_x <= in_end_x) ? in_start_x : in_end_x;
  assign hi_x   = (in_start_x <= in_end_x) ? in_end_x : in_start_x;
  assign lo_y   = (in_start_y <= in_end_y) ? in_start_y : in_end_y;
  assign hi_y   = (in_start_y <= in_end_y) ? in_end_y : in_start_y;
  assign dx_abs = hi_x - lo_x;
  assign dy_fwd = (in_start_x <= in_end_x) ?
                  ($signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y})) :
                  ($signed({1'b0, in_start_y}) - $signed({1'b0, in_end_y}));
  assign rem_step = rem_r + 10'(dstep_r);

  // Sequencer with registered output word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sw_r        <= '0;
      fill_r      <= mfpe_pkg::FILL_ZEROS;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          sw_r <= sw_r + 1'b1;
          if (sw_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pen_r <= in_pen;
            unique case (in_cmd)
              mfpe_pkg::CMD_POINT: begin
                mode_r  <= M_HORZ;
                px_r    <= in_start_x;
                py_r    <= in_start_y;
                hi_r    <= in_start_x;
                state_r <= S_PRD;
              end
              mfpe_pkg::CMD_LINE: begin
                if (in_start_y == in_end_y) begin
                  mode_r <= M_HORZ;
                  px_r   <= lo_x;
                  py_r   <= in_start_y;
                  hi_r   <= hi_x;
                end else if (in_start_x == in_end_x) begin
                  mode_r <= M_VERT;
                  px_r   <= in_start_x;
                  py_r   <= lo_y;
                  hi_r   <= hi_y;
                end else begin
                  // Walk columns from the lower x; remainder stays in [0, dx).
                  mode_r  <= M_SLOPE;
                  px_r    <= lo_x;
                  py_r    <= (in_start_x <= in_end_x) ? in_start_y : in_end_y;
                  hi_r    <= hi_x;
                  dx_r    <= dx_abs;
                  dstep_r <= dy_fwd;
                  rem_r   <= '0;
                end
                state_r <= S_PRD;
              end
              mfpe_pkg::CMD_FILL: begin
                sw_r <= '0;
                if (in_pen == mfpe_pkg::PEN_SET) begin
                  fill_r  <= mfpe_pkg::FILL_ONES;
                  state_r <= S_SWEEP;
                end else if (in_pen == mfpe_pkg::PEN_ERASE) begin
                  fill_r  <= mfpe_pkg::FILL_ZEROS;
                  state_r <= S_SWEEP;
                end
              end
              default: begin
                px_r <= in_start_x;
                py_r <= in_start_y;
                if (({1'b0, in_start_x} < 9'(COLUMNS)) &&
                    ({1'b0, in_start_y} < 9'(PAGES))) begin
                  state_r <= S_RRD;
                end else begin
                  out_valid_r <= 1'b1;
                  out_byte_r  <= 8'd0;
                end
              end
            endcase
          end
        end
        S_PRD: begin
          // Off-screen pixels are skipped.
          state_r <= on_screen ? S_PWR : S_ADV;
        end
        S_PWR: begin
          state_r <= S_ADV;
        end
        S_ADV: begin
          if (mode_r == M_VERT) begin
            if (py_r == hi_r) begin
              state_r <= S_IDLE;
            end else begin
              py_r    <= py_r + 8'd1;
              state_r <= S_PRD;
            end
          end else if (px_r == hi_r) begin
            state_r <= S_IDLE;
          end else begin
            px_r <= px_r + 8'd1;
            if (mode_r == M_SLOPE) begin
              rem_r   <= rem_step;
              state_r <= S_NORM;
            end else begin
              state_r <= S_PRD;
            end
          end
        end
        S_NORM: begin
          // One row step per cycle until the remainder is back in range.
          if (rem_r < 0) begin
            rem_r <= rem_r + $signed({2'b00, dx_r});
            py_r  <= py_r - 8'd1;
          end else if (rem_r >= $signed({2'b00, dx_r})) begin
            rem_r <= rem_r - $signed({2'b00, dx_r});
            py_r  <= py_r + 8'd1;
          end else begin
            state_r <= S_PRD;
          end
        end
        S_RRD: begin
          state_r <= S_RDONE;
        end
        S_RDONE: begin
          out_valid_r <= 1'b1;
          out_byte_r  <= rdata;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mfpe_store.sv =====
// Frame store: one write port, one read port with registered read data.
// Depends on nothing.
module mfpe_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/tb_mono_framebuffer_pen_engine.sv =====
// Testbench for the monochrome framebuffer pen engine: a directed table and random commands,
// with every page-byte read checked against a software image of the screen.
// Depends on mfpe_pkg and the mono_framebuffer_pen_engine RTL.
module tb_mono_framebuffer_pen_engine;

  localparam int COLUMNS = 128;
  localparam int ROWS    = 64;
  localparam int PAGES   = (ROWS + 7) / 8;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int N_RANDOM = 900;
  localparam int NO_CHECK = -1;

  typedef struct {
    mfpe_pkg::cmd_t cmd;
    bit [7:0]       sx;
    bit [7:0]       sy;
    bit [7:0]       ex;
    bit [7:0]       ey;
    mfpe_pkg::pen_t pen;
    int             want;
  } pen_cmd_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_cmd;
  logic [7:0] in_start_x;
  logic [7:0] in_start_y;
  logic [7:0] in_end_x;
  logic [7:0] in_end_y;
  logic [1:0] in_pen;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_page_byte;

  bit [7:0] screen_image [STORE_BYTES];
  bit [7:0] pending_bytes [$];
  int       typed_bytes [$];
  int       error_count;
  int       reads_checked;

  mono_framebuffer_pen_engine #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_pen(in_pen),
    .out_valid(out_valid), .out_ready(out_ready), .out_page_byte(out_page_byte)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Apply the pen to one pixel of the image; off-screen pixels are ignored.
  function automatic void plot_pixel(int x, int y, mfpe_pkg::pen_t pen);
    int idx;
    bit [7:0] mask;
    if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS) return;
    idx = x * PAGES + (y >> 3);
    mask = 8'd1 << (y & 7);
    case (pen)
      mfpe_pkg::PEN_SET:    screen_image[idx] |= mask;
      mfpe_pkg::PEN_INVERT: screen_image[idx] ^= mask;
      default:              screen_image[idx] &= ~mask;
    endcase
  endfunction

  // Floor division with a nonzero divisor.
  function automatic int div_floor(int num, int den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // Update the image for one command; returns 1 with the byte when a read is issued.
  function automatic bit apply_command(pen_cmd_t c, output bit [7:0] rd_byte);
    int x1, y1, x2, y2, lo, hi, i;
    x1 = int'(c.sx); y1 = int'(c.sy); x2 = int'(c.ex); y2 = int'(c.ey);
    rd_byte = 8'h00;
    case (c.cmd)
      mfpe_pkg::CMD_POINT: plot_pixel(x1, y1, c.pen);
      mfpe_pkg::CMD_LINE: begin
        if (y1 == y2) begin
          lo = (x1 < x2) ? x1 : x2;
          hi = (x1 < x2) ? x2 : x1;
          for (i = lo; i <= hi; i++) plot_pixel(i, y1, c.pen);
        end else if (x1 == x2) begin
          lo = (y1 < y2) ? y1 : y2;
          hi = (y1 < y2) ? y2 : y1;
          for (i = lo; i <= hi; i++) plot_pixel(x1, i, c.pen);
        end else begin
          lo = (x1 < x2) ? x1 : x2;
          hi = (x1 < x2) ? x2 : x1;
          for (i = lo; i <= hi; i++)
            plot_pixel(i, y1 + div_floor((i - x1) * (y2 - y1), x2 - x1), c.pen);
        end
      end
      mfpe_pkg::CMD_FILL: begin
        if (c.pen == mfpe_pkg::PEN_SET)
          foreach (screen_image[k]) screen_image[k] = mfpe_pkg::FILL_ONES;
        else if (c.pen == mfpe_pkg::PEN_ERASE)
          foreach (screen_image[k]) screen_image[k] = mfpe_pkg::FILL_ZEROS;
      end
      default: begin
        if (x1 < COLUMNS && y1 < PAGES) rd_byte = screen_image[x1 * PAGES + y1];
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Drive one command word and wait for its acceptance.
  task automatic send_command(pen_cmd_t c);
    bit [7:0] rd;
    int idle;
    idle = $urandom_range(0, 11);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= c.cmd;
    in_start_x <= c.sx;
    in_start_y <= c.sy;
    in_end_x   <= c.ex;
    in_end_y   <= c.ey;
    in_pen     <= c.pen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (apply_command(c, rd)) begin
      pending_bytes.push_back(rd);
      typed_bytes.push_back(c.want);
    end
    @(negedge clk);
  endtask

  function automatic pen_cmd_t mk(mfpe_pkg::cmd_t cmd, int sx, int sy, int ex, int ey,
                                  mfpe_pkg::pen_t pen, int want);
    pen_cmd_t c;
    c.cmd = cmd; c.sx = 8'(sx); c.sy = 8'(sy); c.ex = 8'(ex); c.ey = 8'(ey);
    c.pen = pen; c.want = want;
    return c;
  endfunction

  // Random coordinate, mostly on screen, sometimes at or past the edges.
  function automatic int rand_coord(int limit);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 255);
      1: return limit - 1;
      2: return 0;
      default: return $urandom_range(0, limit - 1);
    endcase
  endfunction

  // Receiver with random stall lengths per word.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected word", out_page_byte, 0);
      end else begin
        bit [7:0] want;
        int typed;
        want = pending_bytes.pop_front();
        typed = typed_bytes.pop_front();
        if (out_page_byte !== want) report_mismatch("page_byte", out_page_byte, want);
        if (typed != NO_CHECK && out_page_byte !== typed[7:0])
          report_mismatch("page_byte (table)", out_page_byte, typed);
        reads_checked++;
      end
    end
  end

  // Stimulus: directed table, then random commands.
  initial begin
    pen_cmd_t table_rows [$];
    pen_cmd_t c;
    int kind;
    in_valid = 1'b0; in_cmd = '0; in_start_x = '0; in_start_y = '0;
    in_end_x = '0; in_end_y = '0; in_pen = '0;
    rst_n = 1'b0;
    error_count = 0; reads_checked = 0;
    foreach (screen_image[k]) screen_image[k] = 8'h00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 0, 0, 0, 0, mfpe_pkg::PEN_ERASE, 8'h00));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 127, 7, 0, 0, mfpe_pkg::PEN_ERASE, 8'h00));
    table_rows.push_back(mk(mfpe_pkg::CMD_POINT, 0, 0, 0, 0, mfpe_pkg::PEN_SET, NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 0, 0, 0, 0, mfpe_pkg::PEN_ERASE, 8'h01));
    table_rows.push_back(mk(mfpe_pkg::CMD_POINT, 127, 63, 0, 0, mfpe_pkg::PEN_INVERT,
                            NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 127, 7, 255, 255, mfpe_pkg::PEN_SET, 8'h80));
    // Off-screen point is ignored; out-of-range reads give zero.
    table_rows.push_back(mk(mfpe_pkg::CMD_POINT, 255, 255, 0, 0, mfpe_pkg::PEN_SET,
                            NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 128, 0, 0, 0, mfpe_pkg::PEN_ERASE, 8'h00));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 0, 8, 0, 0, mfpe_pkg::PEN_ERASE, 8'h00));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 255, 255, 0, 0, mfpe_pkg::PEN_ERASE, 8'h00));
    // Pen value three clears a point.
    table_rows.push_back(mk(mfpe_pkg::CMD_POINT, 0, 0, 0, 0, mfpe_pkg::PEN_NONE, NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 0, 0, 0, 0, mfpe_pkg::PEN_ERASE, 8'h00));
    table_rows.push_back(mk(mfpe_pkg::CMD_LINE, 120, 5, 255, 5, mfpe_pkg::PEN_SET,
                            NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 127, 0, 0, 0, mfpe_pkg::PEN_ERASE, 8'h20));
    table_rows.push_back(mk(mfpe_pkg::CMD_LINE, 3, 255, 3, 50, mfpe_pkg::PEN_SET,
                            NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 3, 7, 0, 0, mfpe_pkg::PEN_ERASE, 8'hff));
    table_rows.push_back(mk(mfpe_pkg::CMD_LINE, 100, 0, 10, 63, mfpe_pkg::PEN_INVERT,
                            NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_LINE, 0, 255, 255, 0, mfpe_pkg::PEN_SET,
                            NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 40, 3, 0, 0, mfpe_pkg::PEN_ERASE, NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_FILL, 0, 0, 0, 0, mfpe_pkg::PEN_SET, NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 64, 4, 0, 0, mfpe_pkg::PEN_ERASE, 8'hff));
    // Invert and pen-three fills leave the store unchanged.
    table_rows.push_back(mk(mfpe_pkg::CMD_FILL, 0, 0, 0, 0, mfpe_pkg::PEN_INVERT, NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_FILL, 255, 255, 255, 255, mfpe_pkg::PEN_NONE,
                            NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 64, 4, 0, 0, mfpe_pkg::PEN_ERASE, 8'hff));
    table_rows.push_back(mk(mfpe_pkg::CMD_FILL, 0, 0, 0, 0, mfpe_pkg::PEN_ERASE, NO_CHECK));
    table_rows.push_back(mk(mfpe_pkg::CMD_READ, 64, 4, 0, 0, mfpe_pkg::PEN_ERASE, 8'h00));
    foreach (table_rows[i]) send_command(table_rows[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 99);
      c.sx = 8'(rand_coord(COLUMNS)); c.sy = 8'(rand_coord(ROWS));
      c.ex = 8'(rand_coord(COLUMNS)); c.ey = 8'(rand_coord(ROWS));
      c.pen = mfpe_pkg::pen_t'($urandom_range(0, 3));
      c.want = NO_CHECK;
      if (kind < 30) c.cmd = mfpe_pkg::CMD_POINT;
      else if (kind < 50) begin
        c.cmd = mfpe_pkg::CMD_LINE;
        // Keep most lines short to bound the run.
        if ($urandom_range(0, 7) != 0) begin
          c.ex = 8'((int'(c.sx) + $urandom_range(0, 20)) % 256);
          c.ey = 8'((int'(c.sy) + $urandom_range(0, 30)) % 256);
          if ($urandom_range(0, 1)) begin
            bit [7:0] t;
            t = c.sx; c.sx = c.ex; c.ex = t;
          end
        end
        if ($urandom_range(0, 9) == 0) c.ey = c.sy;
        if ($urandom_range(0, 9) == 0) c.ex = c.sx;
      end else if (kind < 52) c.cmd = mfpe_pkg::CMD_FILL;
      else begin
        c.cmd = mfpe_pkg::CMD_READ;
        c.sy = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) :
                                              8'($urandom_range(0, 7));
      end
      send_command(c);
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (STORE_BYTES + 64) @(posedge clk);
    $display("Ran %0d directed and %0d random commands; %0d page-byte reads checked.",
             table_rows.size(), N_RANDOM, reads_checked);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("Timeout with %0d reads outstanding.", pending_bytes.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
